FILE: rtl/skyline_rect_allocator_core_defines.svh
// Assertion macros shared by the skyline allocator RTL.
`ifndef SKYLINE_RECT_ALLOCATOR_CORE_DEFINES_SVH
`define SKYLINE_RECT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define SRA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sra: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define SRA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sra: next-cycle check failed");

`else

`define SRA_ASSERT_IMP(lbl, ante, cons)
`define SRA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/sra_pkg.sv
// Shared constants, codes and types of the skyline rectangle allocator.
package sra_pkg;

    localparam int C_MAX_COLS = 1024;
    localparam int C_AW       = $clog2(C_MAX_COLS);
    localparam int C_CW       = $clog2(C_MAX_COLS + 1);
    localparam int C_BW_W     = 11;
    localparam int C_BH_W     = 13;
    localparam int C_HW       = 13;
    localparam int C_PX_W     = 10;
    localparam int C_PY_W     = 12;
    localparam int C_HCAP     = 4096;
    localparam int C_XW       = ((C_CW > C_BW_W) ? C_CW : C_BW_W) + 1;
    localparam int C_CFG_IW   = 2;
    localparam int C_CFG_DW   = 13;
    localparam int C_AWID_W   = 11;
    localparam int C_AHGT_W   = 13;

    localparam logic [C_CFG_IW-1:0] CFG_ATLAS_W = 2'd0;
    localparam logic [C_CFG_IW-1:0] CFG_ATLAS_H = 2'd1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_FWD,
        ST_BWD,
        ST_TAIL,
        ST_EVAL,
        ST_WRITE,
        ST_RESP
    } t_state;

    // tag that travels with a column read to the scan datapath
    typedef struct packed {
        logic            init;
        logic            fwd_v;
        logic            bwd_v;
        logic            first;
        logic            blk_end;
        logic            win_v;
        logic [C_AW-1:0] idx;
    } t_tag;

    typedef struct packed {
        logic            found;
        logic [C_HW-1:0] best;
        logic [C_AW-1:0] pos;
    } t_scan_res;

    typedef struct packed {
        logic              granted;
        logic [C_PX_W-1:0] pos_x;
        logic [C_PY_W-1:0] pos_y;
    } t_resp;

endpackage

FILE: rtl/sra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 13,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sra_scan.sv
// Sliding window maximum datapath: block prefix on the forward pass, suffix and pick on the backward pass.
module sra_scan
    import sra_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_tag            i_tag,
    input  logic [C_HW-1:0] i_col,
    input  logic [C_HW-1:0] i_gval,
    input  logic [C_HW-1:0] i_hlim,
    output logic [C_HW-1:0] o_gw,
    output t_scan_res       o_res
);

    logic [C_HW-1:0] r_g;
    logic [C_HW-1:0] r_h;
    logic            r_found;
    logic [C_HW-1:0] r_best;
    logic [C_AW-1:0] r_pos;

    logic [C_HW-1:0] n_g;
    logic [C_HW-1:0] n_h;
    logic [C_HW-1:0] w_peak;
    logic            w_take;

    always_comb begin
        n_g    = (i_tag.first || (i_col > r_g)) ? i_col : r_g;
        n_h    = (i_tag.blk_end || (i_col > r_h)) ? i_col : r_h;
        w_peak = (n_h > i_gval) ? n_h : i_gval;
        // scan runs right to left, so ties move the pick further left
        w_take = i_tag.bwd_v && i_tag.win_v && (w_peak < i_hlim) &&
                 (!r_found || (w_peak <= r_best));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_tag.init) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
        if (w_take) begin
            r_best <= w_peak;
            r_pos  <= i_tag.idx;
        end
        if (i_tag.fwd_v) begin
            r_g <= n_g;
        end
        if (i_tag.bwd_v) begin
            r_h <= n_h;
        end
    end

    assign o_gw  = n_g;
    assign o_res = '{found: r_found, best: r_best, pos: r_pos};

endmodule

FILE: rtl/sra_ctrl.sv
// Sequencer: clearing sweep, forward and backward scan passes, span writeback, result hand-off.
`include "skyline_rect_allocator_core_defines.svh"

module sra_ctrl
    import sra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [C_BW_W-1:0] i_block_w,
    input  logic [C_BH_W-1:0] i_block_h,
    input  logic [C_CW-1:0]   i_w_eff,
    input  logic [C_HW-1:0]   i_h_eff,
    output t_tag              o_tag,
    output logic [C_AW-1:0]   o_col_raddr,
    output logic              o_col_we,
    output logic [C_AW-1:0]   o_col_waddr,
    output logic [C_HW-1:0]   o_col_wdata,
    output logic [C_AW-1:0]   o_g_raddr,
    input  t_scan_res         i_res,
    output logic              o_resp_valid,
    output t_resp             o_resp,
    input  logic              i_resp_take
);

    t_state            r_state;
    t_state            n_state;
    logic [C_AW-1:0]   r_i;
    logic [C_AW-1:0]   r_ph;
    logic [C_AW-1:0]   r_cnt;
    logic              r_clr_item;
    logic              r_req;
    logic [C_BW_W-1:0] r_bw;
    logic [C_BH_W-1:0] r_bh;
    logic [C_AW-1:0]   r_bwm1;
    logic [C_CW-1:0]   r_nwin;
    logic [C_HW-1:0]   r_newh;
    t_resp             r_resp;
    t_tag              r_tag;
    t_tag              n_tag;

    logic              w_accept;
    logic              w_bad;
    logic              w_at_last;
    logic [C_HW:0]     w_top;
    logic              w_fits;

    always_comb begin
        w_accept  = i_in_valid && (r_state == ST_IDLE);
        w_bad     = (r_bw == '0) || (C_XW'(r_bw) >= C_XW'(i_w_eff));
        w_at_last = (C_CW'(r_i) == (i_w_eff - C_CW'(1)));
        w_top     = {1'b0, i_res.best} + (C_HW + 1)'(r_bh);
        w_fits    = i_res.found && (w_top <= {1'b0, i_h_eff});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_i == C_AW'(C_MAX_COLS - 1)) begin
                    n_state = r_clr_item ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) n_state = ST_START;
            end
            ST_START: begin
                if (r_req == REQ_CLEAR) n_state = ST_CLEAR;
                else if (w_bad)         n_state = ST_RESP;
                else                    n_state = ST_FWD;
            end
            ST_FWD: begin
                if (w_at_last) n_state = ST_BWD;
            end
            ST_BWD: begin
                if (r_i == '0) n_state = ST_TAIL;
            end
            ST_TAIL: n_state = ST_EVAL;
            ST_EVAL: n_state = w_fits ? ST_WRITE : ST_RESP;
            ST_WRITE: begin
                if (r_cnt == r_bwm1) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_resp_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_tag        = '0;
        o_in_ready   = (r_state == ST_IDLE);
        o_col_we     = (r_state == ST_WRITE) || (r_state == ST_CLEAR);
        o_col_waddr  = r_i;
        o_col_wdata  = (r_state == ST_CLEAR) ? '0 : r_newh;
        o_col_raddr  = r_i;
        o_g_raddr    = C_AW'(C_CW'(r_i) + C_CW'(r_bwm1));
        o_resp_valid = (r_state == ST_RESP);
        unique case (r_state)
            ST_START: begin
                n_tag.init = (r_req == REQ_ALLOC) && !w_bad;
            end
            ST_FWD: begin
                n_tag.fwd_v = 1'b1;
                n_tag.first = (r_ph == '0);
                n_tag.idx   = r_i;
            end
            ST_BWD: begin
                n_tag.bwd_v   = 1'b1;
                n_tag.blk_end = (r_ph == r_bwm1) || w_at_last;
                n_tag.win_v   = (C_CW'(r_i) < r_nwin);
                n_tag.idx     = r_i;
            end
            default: begin
                n_tag = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_i        <= '0;
            r_clr_item <= 1'b0;
            r_tag      <= '0;
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;
            unique case (r_state)
                ST_CLEAR: begin
                    r_i <= r_i + C_AW'(1);
                end
                ST_START: begin
                    r_i  <= '0;
                    r_ph <= '0;
                    if (r_req == REQ_CLEAR) begin
                        r_clr_item <= 1'b1;
                    end
                end
                ST_FWD: begin
                    if (!w_at_last) begin
                        r_i  <= r_i + C_AW'(1);
                        r_ph <= (r_ph == r_bwm1) ? '0 : r_ph + C_AW'(1);
                    end
                end
                ST_BWD: begin
                    r_i  <= r_i - C_AW'(1);
                    r_ph <= (r_ph == '0) ? r_bwm1 : r_ph - C_AW'(1);
                end
                ST_EVAL: begin
                    r_i   <= i_res.pos;
                    r_cnt <= '0;
                end
                ST_WRITE: begin
                    r_i   <= r_i + C_AW'(1);
                    r_cnt <= r_cnt + C_AW'(1);
                end
                ST_RESP: begin
                    r_clr_item <= 1'b0;
                end
                default: begin
                    r_i <= r_i;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_bw  <= i_block_w;
            r_bh  <= i_block_h;
        end
        if (r_state == ST_START) begin
            r_bwm1 <= C_AW'(r_bw - C_BW_W'(1));
            r_nwin <= i_w_eff - C_CW'(r_bw);
            r_resp <= '{granted: (r_req == REQ_CLEAR), pos_x: '0, pos_y: '0};
        end
        if (r_state == ST_EVAL) begin
            r_newh <= w_top[C_HW-1:0];
            if (w_fits) begin
                r_resp <= '{granted: 1'b1,
                            pos_x:   C_PX_W'(i_res.pos),
                            pos_y:   i_res.best[C_PY_W-1:0]};
            end else begin
                r_resp <= '0;
            end
        end
    end

    assign o_tag  = r_tag;
    assign o_resp = r_resp;

    `SRA_ASSERT_NXT(a_accept_start, w_accept, r_state == ST_START)
    `SRA_ASSERT_IMP(a_no_rw_overlap, o_col_we, !r_tag.fwd_v && !r_tag.bwd_v)
    `SRA_ASSERT_NXT(a_resp_hold, o_resp_valid && !i_resp_take,
                    o_resp_valid && $stable(o_resp))

endmodule

FILE: rtl/skyline_rect_allocator_core.sv
// Skyline rectangle allocator: top level with ports, config registers and output register.
//
// Slave stream: one beat is a request; tuser[0] is req_type (0 allocate, 1 clear),
// tdata carries block_w and block_h. Master stream: one beat per request; tuser[0]
// is granted, tdata carries pos_x and pos_y (both 0 when not granted).
// Config: write i_cfg_idx 0 for atlas_width, 1 for atlas_height, only while idle.
// Items are handled one at a time; tready is high only while no request is open.
// Allocate, with W the columns in use: a forward pass builds block prefix maxima in
// a scratch RAM, a backward pass forms suffix maxima and picks the span, then the
// span is written back into the skyline RAM one column a cycle; with no fitting
// span there is no write-back.
// A rejected request (zero width or width not below W) skips both scan passes.
// Clear: a sweep that writes zero to all 1024 columns of the skyline RAM.
// After reset the same sweep runs with tready low; config writes are
// taken during it. The result sits in an output register, so a stalled receiver
// only holds the next result back; the block stays closed until the pending
// result has moved into that register.
module skyline_rect_allocator_core
    import sra_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [23:0]         i_s_axis_tdata,   // block_w[10:0], block_h[23:11]
    input  logic                i_s_axis_tuser,   // req_type
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [23:0]         o_m_axis_tdata,   // pos_x[9:0], pos_y[21:10], zero[23:22]
    output logic                o_m_axis_tuser,   // granted
    input  logic                i_cfg_we,
    input  logic [C_CFG_IW-1:0] i_cfg_idx,
    input  logic [C_CFG_DW-1:0] i_cfg_wdata
);

    logic [C_AWID_W-1:0] r_atlas_w;
    logic [C_AHGT_W-1:0] r_atlas_h;
    logic                r_out_v;
    t_resp               r_out;

    logic [C_CW-1:0]     w_w_eff;
    logic [C_HW-1:0]     w_h_eff;
    t_tag                w_tag;
    logic [C_AW-1:0]     w_col_raddr;
    logic                w_col_we;
    logic [C_AW-1:0]     w_col_waddr;
    logic [C_HW-1:0]     w_col_wdata;
    logic [C_HW-1:0]     w_col_rdata;
    logic [C_AW-1:0]     w_g_raddr;
    logic [C_HW-1:0]     w_g_rdata;
    logic [C_HW-1:0]     w_gw;
    t_scan_res           w_res;
    logic                w_resp_valid;
    t_resp               w_resp;
    logic                w_resp_take;

    always_comb begin
        w_w_eff = (C_XW'(r_atlas_w) > C_XW'(C_MAX_COLS)) ? C_CW'(C_MAX_COLS)
                                                          : C_CW'(r_atlas_w);
        w_h_eff = (r_atlas_h > C_AHGT_W'(C_HCAP)) ? C_HW'(C_HCAP) : r_atlas_h;
        w_resp_take = w_resp_valid && (!r_out_v || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= C_AWID_W'(1024);
            r_atlas_h <= C_AHGT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATLAS_W: r_atlas_w <= i_cfg_wdata[C_AWID_W-1:0];
                CFG_ATLAS_H: r_atlas_h <= i_cfg_wdata[C_AHGT_W-1:0];
                default: begin
                    r_atlas_w <= r_atlas_w;
                end
            endcase
        end
    end

    // output register: load when empty or when the current beat leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_resp_take) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
        if (w_resp_take) begin
            r_out <= w_resp;
        end
    end

    sra_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_req_type   (i_s_axis_tuser),
        .i_block_w    (i_s_axis_tdata[10:0]),
        .i_block_h    (i_s_axis_tdata[23:11]),
        .i_w_eff      (w_w_eff),
        .i_h_eff      (w_h_eff),
        .o_tag        (w_tag),
        .o_col_raddr  (w_col_raddr),
        .o_col_we     (w_col_we),
        .o_col_waddr  (w_col_waddr),
        .o_col_wdata  (w_col_wdata),
        .o_g_raddr    (w_g_raddr),
        .i_res        (w_res),
        .o_resp_valid (w_resp_valid),
        .o_resp       (w_resp),
        .i_resp_take  (w_resp_take)
    );

    sra_ram #(
        .DEPTH (C_MAX_COLS),
        .WIDTH (C_HW)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (w_col_waddr),
        .i_wdata (w_col_wdata),
        .i_raddr (w_col_raddr),
        .o_rdata (w_col_rdata)
    );

    // scratch RAM of block prefix maxima, written on the forward pass
    sra_ram #(
        .DEPTH (C_MAX_COLS),
        .WIDTH (C_HW)
    ) u_pre_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag.fwd_v),
        .i_waddr (w_tag.idx),
        .i_wdata (w_gw),
        .i_raddr (w_g_raddr),
        .o_rdata (w_g_rdata)
    );

    sra_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_col   (w_col_rdata),
        .i_gval  (w_g_rdata),
        .i_hlim  (w_h_eff),
        .o_gw    (w_gw),
        .o_res   (w_res)
    );

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {2'b00, r_out.pos_y, r_out.pos_x};
    assign o_m_axis_tuser  = r_out.granted;

endmodule
